FILE: rtl/core/integer_arith_unit_div_sqrt_defines.svh
// Assertion macros for the arithmetic unit
`ifndef INTEGER_ARITH_UNIT_DIV_SQRT_DEFINES_SVH
`define INTEGER_ARITH_UNIT_DIV_SQRT_DEFINES_SVH
// Implication checked on every edge outside reset
`define IAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iau check failed");
// Next-cycle implication
`define IAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iau check failed");
`endif

FILE: rtl/core/iau_pkg.sv
// Shared types and constants for the arithmetic unit
package iau_pkg;
  localparam logic [2:0] ModeAdd  = 3'd0;
  localparam logic [2:0] ModeSub  = 3'd1;
  localparam logic [2:0] ModeMul  = 3'd2;
  localparam logic [2:0] ModeDiv  = 3'd3;
  localparam logic [2:0] ModeSqrt = 3'd4;

  // control that travels with an item along the cell chain
  typedef struct packed {
    logic       vld;
    logic [2:0] mode;
  } ctl_t;
endpackage

FILE: rtl/core/iau_cell.sv
// One step cell: a restoring divide step and a square-root digit step, registered
module iau_cell #(
  parameter int W = 32,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  iau_pkg::ctl_t     ctl_in,
  input  logic [W-1:0]      a_in,
  input  logic [W-1:0]      b_in,
  input  logic [W-1:0]      q_in,
  input  logic [W-1:0]      r_in,
  input  logic [W-1:0]      sx_in,
  input  logic [W-1:0]      sres_in,
  input  logic [2*W-1:0]    pass_in,
  output iau_pkg::ctl_t     ctl_out,
  output logic [W-1:0]      a_out,
  output logic [W-1:0]      b_out,
  output logic [W-1:0]      q_out,
  output logic [W-1:0]      r_out,
  output logic [W-1:0]      sx_out,
  output logic [W-1:0]      sres_out,
  output logic [2*W-1:0]    pass_out
);
  localparam int Bit = W - 1 - IDX;
  localparam int SqSteps = (((W - 1) & ~1) / 2) + 1;
  localparam int SqTop = (W - 1) & ~1;
  // cells past the last root digit only pass the root through
  localparam int SqShift = (IDX < SqSteps) ? (SqTop - 2 * IDX) : 0;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] q_next, r_next;
  logic [W:0]   sq_sum;
  logic [W-1:0] sx_next, sres_next;

  always_comb begin
    trial = {r_in, a_in[Bit]};
    diff = trial - {1'b0, b_in};
    q_next = q_in;
    if (!diff[W]) begin
      r_next = diff[W-1:0];
      q_next[Bit] = 1'b1;
    end else begin
      r_next = trial[W-1:0];
    end
    sx_next = sx_in;
    sres_next = sres_in;
    if (IDX < SqSteps) begin
      sq_sum = {1'b0, sres_in} + ({{W{1'b0}}, 1'b1} << SqShift);
      if ({1'b0, sx_in} >= sq_sum) begin
        sx_next = sx_in - sq_sum[W-1:0];
        sres_next = (sres_in >> 1) + (W'(1) << SqShift);
      end else begin
        sres_next = sres_in >> 1;
      end
    end else begin
      sq_sum = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.vld <= 1'b0;
    end else begin
      ctl_out.vld <= ctl_in.vld;
    end
    ctl_out.mode <= ctl_in.mode;
    a_out <= a_in;
    b_out <= b_in;
    q_out <= q_next;
    r_out <= r_next;
    sx_out <= sx_next;
    sres_out <= sres_next;
    pass_out <= pass_in;
  end
endmodule

FILE: rtl/core/integer_arith_unit_div_sqrt.sv
// Top level of the arithmetic unit: entry stage, cell chain and result stage
// Pipelined unsigned add/subtract/multiply/divide/square-root unit. A request
// is taken every cycle while busy is low (busy is never raised). Each request
// passes an entry register, a chain of OPERAND_BITS step cells (one quotient
// bit per cell, and one root digit per cell until the root is complete) and a
// result register that drives done; the receiver cannot stall and must take
// each result in its cycle.
`include "integer_arith_unit_div_sqrt_defines.svh"
module integer_arith_unit_div_sqrt #(
  parameter int OPERAND_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [2:0]                            mode,
  input  logic [31:0]                           operand_a,
  input  logic [31:0]                           operand_b,
  output logic                                  done,
  output logic [63:0]                           result_value,
  output logic [31:0]                           remainder_value,
  output logic                                  is_negative,
  output logic                                  divide_by_zero
);
  localparam int W = OPERAND_BITS;

  iau_pkg::ctl_t   ctl  [W+1];
  logic [W-1:0]    a    [W+1];
  logic [W-1:0]    b    [W+1];
  logic [W-1:0]    q    [W+1];
  logic [W-1:0]    r    [W+1];
  logic [W-1:0]    sx   [W+1];
  logic [W-1:0]    sres [W+1];
  logic [2*W-1:0]  pass [W+1];

  logic [W-1:0]   am, bm;
  logic [2*W-1:0] fast;

  assign busy = 1'b0;
  assign am = operand_a[W-1:0];
  assign bm = operand_b[W-1:0];

  // add, subtract and multiply are done at entry and ride the chain
  always_comb begin
    unique case (mode)
      iau_pkg::ModeAdd: fast = {{W{1'b0}}, am} + {{W{1'b0}}, bm};
      iau_pkg::ModeSub: fast = (am < bm) ? {{W{1'b0}}, bm - am} : {{W{1'b0}}, am - bm};
      iau_pkg::ModeMul: fast = {{W{1'b0}}, am} * {{W{1'b0}}, bm};
      default:          fast = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].vld <= 1'b0;
    end else begin
      ctl[0].vld <= start;
    end
    ctl[0].mode <= mode;
    a[0] <= am;
    b[0] <= bm;
    q[0] <= '0;
    r[0] <= '0;
    sx[0] <= am;
    sres[0] <= '0;
    pass[0] <= fast;
  end

  for (genvar i = 0; i < W; i++) begin : g_cell
    iau_cell #(.W(W), .IDX(i)) u_cell (
      .clk(clk), .rst(rst),
      .ctl_in(ctl[i]), .a_in(a[i]), .b_in(b[i]), .q_in(q[i]), .r_in(r[i]),
      .sx_in(sx[i]), .sres_in(sres[i]), .pass_in(pass[i]),
      .ctl_out(ctl[i+1]), .a_out(a[i+1]), .b_out(b[i+1]), .q_out(q[i+1]),
      .r_out(r[i+1]), .sx_out(sx[i+1]), .sres_out(sres[i+1]),
      .pass_out(pass[i+1])
    );
  end

  logic        bz;
  assign bz = (b[W] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[W].vld;
    end
    result_value <= '0;
    remainder_value <= '0;
    is_negative <= 1'b0;
    divide_by_zero <= 1'b0;
    unique case (ctl[W].mode)
      iau_pkg::ModeAdd, iau_pkg::ModeMul: result_value <= 64'(pass[W]);
      iau_pkg::ModeSub: begin
        result_value <= 64'(pass[W]);
        is_negative <= a[W] < b[W];
      end
      iau_pkg::ModeDiv: begin
        if (bz) begin
          divide_by_zero <= 1'b1;
        end else begin
          result_value <= 64'(q[W]);
          remainder_value <= 32'(r[W]);
        end
      end
      iau_pkg::ModeSqrt: result_value <= 64'(sres[W]);
      default: ;
    endcase
  end

  `IAU_ASSERT_IMP(a_busy_low, 1'b1, !busy)
  `IAU_ASSERT_NEXT(a_vld_done, ctl[W].vld, done)
  `IAU_ASSERT_IMP(a_one_flag, done, !(is_negative && divide_by_zero))
  `IAU_ASSERT_IMP(a_dz_zero, done && divide_by_zero, result_value == 64'd0 && remainder_value == 32'd0)
endmodule

FILE: verif/tb_integer_arith_unit_div_sqrt.sv
// Self-checking testbench for the pipelined integer add/sub/mul/div/sqrt unit
`timescale 1ns / 100ps
module tb_integer_arith_unit_div_sqrt;

  localparam int OpBits = 32;
  localparam int Latency = OpBits + 2;
  localparam int MaxCycles = 200000;
  localparam int NumRandom = 1530;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] a;
    logic [31:0] b;
  } request_t;

  typedef struct packed {
    logic [63:0] value;
    logic [31:0] rem;
    logic        neg;
    logic        dz;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  mode = '0;
  logic [31:0] operand_a = '0;
  logic [31:0] operand_b = '0;
  logic        done;
  logic [63:0] result_value;
  logic [31:0] remainder_value;
  logic        is_negative;
  logic        divide_by_zero;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  bit       feed_done = 1'b0;
  bit       drain_wait = 1'b0;
  int       hold_cycles = 0;
  int       errors = 0;
  int       cycle_count = 0;

  integer_arith_unit_div_sqrt #(.OPERAND_BITS(OpBits)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .operand_a(operand_a), .operand_b(operand_b), .done(done),
    .result_value(result_value), .remainder_value(remainder_value),
    .is_negative(is_negative), .divide_by_zero(divide_by_zero)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_root(logic [63:0] x);
    logic [63:0] bit_val;
    logic [63:0] root;
    root = '0;
    bit_val = 64'd1 << ((OpBits - 1) & ~1);
    while (bit_val != 0) begin
      if (x >= root + bit_val) begin
        x = x - (root + bit_val);
        root = (root >> 1) + bit_val;
      end else begin
        root = root >> 1;
      end
      bit_val = bit_val >> 2;
    end
    return root;
  endfunction

  function automatic answer_t compute_answer(request_t r);
    answer_t ans;
    logic [63:0] a;
    logic [63:0] b;
    ans = '0;
    a = {32'd0, r.a};
    b = {32'd0, r.b};
    case (r.mode)
      iau_pkg::ModeAdd: ans.value = a + b;
      iau_pkg::ModeSub: begin
        if (a < b) begin
          ans.value = b - a;
          ans.neg = 1'b1;
        end else begin
          ans.value = a - b;
        end
      end
      iau_pkg::ModeMul: ans.value = a * b;
      iau_pkg::ModeDiv: begin
        if (b == 0) begin
          ans.dz = 1'b1;
        end else begin
          ans.value = a / b;
          ans.rem = 32'(a % b);
        end
      end
      iau_pkg::ModeSqrt: ans.value = floor_root(a);
      default: ans = '0;
    endcase
    return ans;
  endfunction

  function automatic logic [31:0] random_operand();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 15));
      3: return 32'(1) << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic push_request(logic [2:0] m, logic [31:0] a, logic [31:0] b);
    request_t r;
    r.mode = m;
    r.a = a;
    r.b = b;
    pending_requests.push_back(r);
  endtask

  initial begin
    logic [2:0] m;
    push_request(iau_pkg::ModeAdd, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeAdd, 32'd0, 32'd0);
    push_request(iau_pkg::ModeSub, 32'd5, 32'd9);
    push_request(iau_pkg::ModeSub, 32'hFFFF_FFFF, 32'd0);
    push_request(iau_pkg::ModeSub, 32'd0, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeSub, 32'd7, 32'd7);
    push_request(iau_pkg::ModeMul, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeMul, 32'd0, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeDiv, 32'd100, 32'd0);
    push_request(iau_pkg::ModeDiv, 32'hFFFF_FFFF, 32'd1);
    push_request(iau_pkg::ModeDiv, 32'd3, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeDiv, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(iau_pkg::ModeSqrt, 32'hFFFF_FFFF, 32'h1234_5678);
    push_request(iau_pkg::ModeSqrt, 32'd0, 32'd0);
    push_request(iau_pkg::ModeSqrt, 32'h4000_0000, 32'd0);
    push_request(iau_pkg::ModeSqrt, 32'h3FFF_FFFF, 32'd0);
    push_request(iau_pkg::ModeSqrt, 32'hFFFE_0001, 32'd0);
    push_request(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(3'd6, 32'h1234, 32'h5678);
    push_request(3'd7, 32'hFFFF_FFFF, 32'd0);
    for (int i = 0; i < NumRandom; i++) begin
      m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
      push_request(m, random_operand(), random_operand());
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // request taken this edge
      if (hold_cycles > 0 || pending_requests.size() == 0 ||
          (pending_requests.size() == 770 && !drain_wait)) begin
        start <= 1'b0;
        if (pending_requests.size() == 0) feed_done <= 1'b1;
        if (pending_requests.size() == 770) drain_wait <= 1'b1;
      end else begin
        launch_next();
      end
    end else if (!start) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end else if (pending_requests.size() == 0) begin
        feed_done <= 1'b1;
      end else if (pending_requests.size() == 770 && !drain_wait) begin
        drain_wait <= 1'b1;
      end else if (!(drain_wait && pending_requests.size() == 770 &&
                     expected_answers.size() != 0)) begin
        launch_next();
      end
    end
  end

  task automatic launch_next();
    request_t r;
    r = pending_requests.pop_front();
    expected_answers.push_back(compute_answer(r));
    mode <= r.mode;
    operand_a <= r.a;
    operand_b <= r.b;
    start <= 1'b1;
    // mostly back-to-back requests, with a random gap after about one in four
    hold_cycles <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 0;
  endtask

  // monitor
  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result value=%h", $time, result_value);
        errors++;
      end else begin
        exp_ans = expected_answers.pop_front();
        if (result_value !== exp_ans.value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   exp_ans.value, result_value);
          errors++;
        end
        if (remainder_value !== exp_ans.rem) begin
          $display("%0t: remainder_value expected %h actual %h", $time,
                   exp_ans.rem, remainder_value);
          errors++;
        end
        if (is_negative !== exp_ans.neg) begin
          $display("%0t: is_negative expected %b actual %b", $time,
                   exp_ans.neg, is_negative);
          errors++;
        end
        if (divide_by_zero !== exp_ans.dz) begin
          $display("%0t: divide_by_zero expected %b actual %b", $time,
                   exp_ans.dz, divide_by_zero);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (feed_done && expected_answers.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
